/* rtl/spcc_pkg.sv */
package spcc_pkg;

	localparam int FRAME_LENGTH  = 6;
	localparam int POSITION_BITS = 32;

	localparam logic [7:0] CharHome  = 8'h48;
	localparam logic [7:0] CharLaser = 8'h4C;

	localparam logic OpTick = 1'b0;
	localparam logic OpByte = 1'b1;

	typedef struct packed {
		logic        done;
		logic        home;
		logic        load;
		logic [15:0] dest;
	} frame_cmd_t;

endpackage

/* rtl/stepper_position_command_controller.sv */
// A request accepted into the request register moves on to the result ports through the result register.
// Throughput: one request per cycle while the result side keeps taking results.
// The request register and the result register each hold one entry, so one more
// request is taken while a finished result waits for out_ready; then the input stalls.
// Reset (arst_n low, asynchronous) clears position, destination, homing,
// the frame byte counter and all valid flags.
module stepper_position_command_controller
	import spcc_pkg::*;
#(
	parameter int FrameLength  = FRAME_LENGTH,
	parameter int PositionBits = POSITION_BITS
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               operation,
	input  logic [7:0]         rx_byte,
	input  logic               endstop_high,
	output logic               out_valid,
	input  logic               out_ready,
	output logic               step_pulse,
	output logic               step_dec,
	output logic signed [31:0] current_position,
	output logic [15:0]        target_position,
	output logic               homing_active,
	output logic               frame_done
);

	logic       valid_s1;
	logic       op_s1;
	logic [7:0] byte_s1;
	logic       endstop_s1;
	logic       advance;

	logic signed [PositionBits-1:0] position_q;
	logic [15:0]                    destination_q;
	logic                           homing_q;

	logic signed [PositionBits-1:0] pos_next;
	logic signed [PositionBits-1:0] dest_ext;
	logic [15:0]                    dest_next;
	logic                           homing_next;
	logic                           pulse;
	logic                           left;
	logic [63:0]                    pos_wide;
	frame_cmd_t                     cmd;

	logic               out_valid_q;
	logic               pulse_q;
	logic               left_q;
	logic signed [31:0] position_out_q;
	logic [15:0]        target_q;
	logic               homing_out_q;
	logic               done_q;

	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			op_s1      <= operation;
			byte_s1    <= rx_byte;
			endstop_s1 <= endstop_high;
		end
	end

	spcc_framer #(
		.FrameLength(FrameLength)
	) u_framer (
		.clk    (clk),
		.arst_n (arst_n),
		.byte_en(advance && (op_s1 == OpByte)),
		.rx_byte(byte_s1),
		.cmd    (cmd)
	);

	assign dest_ext = signed'(PositionBits'(destination_q));

	always_comb begin
		pos_next    = position_q;
		dest_next   = destination_q;
		homing_next = homing_q;
		pulse       = 1'b0;
		left        = 1'b0;
		if (op_s1 == OpByte) begin
			if (cmd.home) begin
				homing_next = 1'b1;
			end
			if (cmd.load) begin
				dest_next = cmd.dest;
			end
		end else if (homing_q) begin
			if (endstop_s1) begin
				pos_next = position_q - 1'b1;
				pulse    = 1'b1;
				left     = 1'b1;
			end else begin
				pos_next    = '0;
				homing_next = 1'b0;
			end
		end else if (position_q < dest_ext) begin
			pos_next = position_q + 1'b1;
			pulse    = 1'b1;
		end else if (position_q > dest_ext) begin
			pos_next = position_q - 1'b1;
			pulse    = 1'b1;
			left     = 1'b1;
		end
	end

	assign pos_wide = 64'(pos_next);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			position_q    <= '0;
			destination_q <= '0;
			homing_q      <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			if (advance) begin
				position_q    <= pos_next;
				destination_q <= dest_next;
				homing_q      <= homing_next;
			end
			out_valid_q <= advance || (out_valid_q && !out_ready);
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			pulse_q        <= pulse;
			left_q         <= left;
			position_out_q <= signed'(pos_wide[31:0]);
			target_q       <= dest_next;
			homing_out_q   <= homing_next;
			done_q         <= cmd.done;
		end
	end

	assign out_valid        = out_valid_q;
	assign step_pulse       = pulse_q;
	assign step_dec         = left_q;
	assign current_position = position_out_q;
	assign target_position  = target_q;
	assign homing_active    = homing_out_q;
	assign frame_done       = done_q;

endmodule

/* rtl/spcc_framer.sv */
module spcc_framer
	import spcc_pkg::*;
#(
	parameter int FrameLength = FRAME_LENGTH
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       byte_en,
	input  logic [7:0] rx_byte,
	output frame_cmd_t cmd
);

	localparam int CountW = $clog2(FrameLength);
	localparam logic [CountW-1:0] LastIdx = CountW'(FrameLength - 1);

	logic [7:0]        bytes_q [FrameLength];
	logic [CountW-1:0] count_q;
	logic [7:0]        frame [FrameLength];
	logic              all_home;
	logic              last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (byte_en) begin
			count_q <= last ? '0 : count_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_en) begin
			bytes_q[count_q] <= rx_byte;
		end
	end

	assign last = (count_q == LastIdx);

	// The closing byte of a frame is taken straight from the input.
	always_comb begin
		frame[FrameLength-1] = rx_byte;
		for (int i = 0; i < FrameLength - 1; i++) begin
			frame[i] = bytes_q[i];
		end
		all_home = 1'b1;
		for (int i = 0; i < FrameLength; i++) begin
			if (frame[i] != CharHome) begin
				all_home = 1'b0;
			end
		end
		cmd.done = byte_en && last;
		cmd.home = cmd.done && all_home;
		cmd.load = cmd.done && (frame[0] == CharLaser);
		cmd.dest = {frame[3], frame[4]};
	end

endmodule

/* rtl/spcc_checker.sv */
module spcc_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               out_valid,
	input logic               out_ready,
	input logic               step_pulse,
	input logic               step_dec,
	input logic signed [31:0] current_position,
	input logic               homing_active,
	input logic               frame_done
);

	// A stalled result stays on the port unchanged.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(current_position))
		else $error("result changed while stalled");

	// A direction is only reported together with a step.
	a_left_needs_step: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && step_dec |-> step_pulse)
		else $error("step_dec without step_pulse");

	// A byte request never moves the motor.
	a_byte_no_step: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && frame_done |-> !step_pulse)
		else $error("step issued on a completed frame");

	// Any step taken while homing goes left.
	a_homing_left: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && homing_active && step_pulse |-> step_dec)
		else $error("homing step to the right");

endmodule

bind stepper_position_command_controller spcc_checker u_spcc_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.out_valid       (out_valid),
	.out_ready       (out_ready),
	.step_pulse      (step_pulse),
	.step_dec        (step_dec),
	.current_position(current_position),
	.homing_active   (homing_active),
	.frame_done      (frame_done)
);
